// ----- design/hdct_pkg.sv -----
// Shared types and constants for the hard-disk contact time engine.
package hdct_pkg;

   typedef enum logic [2:0] {
      OUT_HIT     = 3'd0,
      OUT_APART   = 3'd1,
      OUT_REJECT  = 3'd2,
      OUT_NO_ROOT = 3'd3,
      OUT_LATE    = 3'd4
   } hdct_outcome_type;

   localparam int REG_BOX_WIDTH  = 0;
   localparam int REG_BOX_HEIGHT = 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int SQRT_STEPS  = 64;

   typedef struct packed {
      hdct_outcome_type   outcome;
      logic signed [31:0] bound;
      logic [62:0]        b_mag;
      logic [62:0]        dv2;
      logic [127:0]       disc;
   } hdct_job_type;

   typedef struct packed {
      hdct_outcome_type   outcome;
      logic signed [31:0] bound;
      logic [62:0]        b_mag;
      logic [62:0]        dv2;
      logic [127:0]       rad;
      logic [64:0]        rem;
      logic [63:0]        root;
   } hdct_sqrt_type;

endpackage

// ----- design/hard_disk_collision_time_top.sv -----
// Throughput: one word per cycle unless the queue is full or the receiver stalls;
// the square root takes 64 stages and the divider 64 + FRAC_BITS stages, each
// resolving one result bit.
// Reset clears all valid flags and the queue, sets both box registers to Q16.16 64.0.
// Front and back are split by a four-word queue, so each side stalls on its own.
module hard_disk_collision_time_top
   import hdct_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_a_pos_x,
   input  logic signed [31:0] req_a_pos_y,
   input  logic signed [31:0] req_a_vel_x,
   input  logic signed [31:0] req_a_vel_y,
   input  logic signed [31:0] req_b_pos_x,
   input  logic signed [31:0] req_b_pos_y,
   input  logic signed [31:0] req_b_vel_x,
   input  logic signed [31:0] req_b_vel_y,
   input  logic [30:0]        req_b_age,
   input  logic [30:0]        req_contact_distance,
   input  logic               req_near_edge,
   input  logic signed [31:0] req_bound_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_bound_out,
   output logic [2:0]         rsp_outcome,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [30:0]  box_width_ff, box_width_in;
   logic [30:0]  box_height_ff, box_height_in;
   logic         csr_write;
   logic         front_valid, queue_full, queue_valid, back_pop;
   hdct_job_type front_job, queue_head;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      box_width_in  = box_width_ff;
      box_height_in = box_height_ff;
      if (csr_write) begin
         if (csr_paddr[2] == 1'(REG_BOX_HEIGHT)) begin
            box_height_in = csr_pwdata[30:0];
         end else begin
            box_width_in = csr_pwdata[30:0];
         end
      end
      if (csr_paddr[2] == 1'(REG_BOX_WIDTH)) begin
         csr_prdata = {1'b0, box_width_ff};
      end else begin
         csr_prdata = {1'b0, box_height_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_width_ff  <= 31'd4194304;
         box_height_ff <= 31'd4194304;
      end else begin
         box_width_ff  <= box_width_in;
         box_height_ff <= box_height_in;
      end
   end

   hdct_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_stall         (req_stall),
      .a_pos_x          (req_a_pos_x),
      .a_pos_y          (req_a_pos_y),
      .a_vel_x          (req_a_vel_x),
      .a_vel_y          (req_a_vel_y),
      .b_pos_x          (req_b_pos_x),
      .b_pos_y          (req_b_pos_y),
      .b_vel_x          (req_b_vel_x),
      .b_vel_y          (req_b_vel_y),
      .b_age            (req_b_age),
      .contact_distance (req_contact_distance),
      .near_edge        (req_near_edge),
      .bound_in         (req_bound_in),
      .box_width        (box_width_ff),
      .box_height       (box_height_ff),
      .job_full         (queue_full),
      .job_valid        (front_valid),
      .job              (front_job)
   );

   hdct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_job),
      .full       (queue_full),
      .pop        (back_pop),
      .head_valid (queue_valid),
      .head       (queue_head)
   );

   hdct_back #(
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (queue_valid),
      .job           (queue_head),
      .pop           (back_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hit       (rsp_hit),
      .rsp_bound_out (rsp_bound_out),
      .rsp_outcome   (rsp_outcome)
   );

endmodule

// ----- design/hdct_front.sv -----
// Front pipeline: relative motion, periodic fold, products and early classification.
module hdct_front
   import hdct_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  logic signed [31:0] a_pos_x,
   input  logic signed [31:0] a_pos_y,
   input  logic signed [31:0] a_vel_x,
   input  logic signed [31:0] a_vel_y,
   input  logic signed [31:0] b_pos_x,
   input  logic signed [31:0] b_pos_y,
   input  logic signed [31:0] b_vel_x,
   input  logic signed [31:0] b_vel_y,
   input  logic [30:0]        b_age,
   input  logic [30:0]        contact_distance,
   input  logic               near_edge,
   input  logic signed [31:0] bound_in,
   input  logic [30:0]        box_width,
   input  logic [30:0]        box_height,
   input  logic               job_full,
   output logic               job_valid,
   output hdct_job_type       job
);

   localparam int LW = 98 + FRAC_BITS;

   function automatic logic signed [31:0] sat31(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -66'sd2147483647) begin
         return 32'sh80000001;
      end else begin
         return v[31:0];
      end
   endfunction

   function automatic logic signed [65:0] fold(input logic signed [65:0] d,
                                               input logic [30:0] size);
      logic signed [67:0] twice;
      logic signed [67:0] sz;
      twice = 68'(d) <<< 1;
      sz = 68'(signed'({1'b0, size}));
      if (twice > sz) begin
         return 66'(68'(d) - sz);
      end else if (twice < -sz) begin
         return 66'(68'(d) + sz);
      end else begin
         return d;
      end
   endfunction

   logic [7:0] vld_ff;
   logic [7:0] vld_in;
   logic       adv;

   logic signed [63:0] mul_x, mul_y;

   logic signed [63:0] shx_ff, shy_ff;
   logic signed [32:0] dax_ff, day_ff;
   logic signed [31:0] dvx1_ff, dvy1_ff;
   logic [30:0]        cd1_ff;
   logic               edge1_ff;
   logic signed [31:0] tb1_ff;

   logic signed [65:0] dx2_ff, dy2_ff;
   logic signed [31:0] dvx2_ff, dvy2_ff;
   logic [30:0]        cd2_ff;
   logic               edge2_ff;
   logic signed [31:0] tb2_ff;

   logic signed [31:0] dx3_ff, dy3_ff, dvx3_ff, dvy3_ff;
   logic [30:0]        cd3_ff;
   logic signed [31:0] tb3_ff;

   logic signed [63:0] bx4_ff, by4_ff;
   logic [61:0]        xx4_ff, yy4_ff, cc4_ff, vx4_ff, vy4_ff;
   logic signed [31:0] tb4_ff;

   logic signed [63:0] b5_ff, a5_ff;
   logic [62:0]        dv25_ff;
   logic signed [31:0] tb5_ff;

   logic [62:0]        bm5, am5;
   logic [31:0]        tm5;
   logic [63:0]        lp0_ff, lp1_ff, pp0_ff, pp1_ff, pp2_ff;
   logic [63:0]        qp0_ff, qp1_ff, qp2_ff, qp3_ff;
   logic               bpos6_ff, lneg6_ff;
   logic signed [63:0] a6_ff;
   logic [62:0]        dv26_ff, bm6_ff;
   logic signed [31:0] tb6_ff;

   logic [95:0]        lm7_ff;
   logic [127:0]       p7_ff, q7_ff;
   logic               bpos7_ff, lneg7_ff;
   logic signed [63:0] a7_ff;
   logic [62:0]        dv27_ff, bm7_ff;
   logic signed [31:0] tb7_ff;

   logic signed [LW-1:0] l_val, r_val;
   hdct_job_type         job_ff;
   hdct_job_type         job_in;

   assign adv      = !(vld_ff[7] && job_full);
   assign in_stall = !adv;
   assign vld_in   = {vld_ff[6:0], in_valid};

   assign mul_x = 64'(signed'({1'b0, b_age})) * 64'(b_vel_x);
   assign mul_y = 64'(signed'({1'b0, b_age})) * 64'(b_vel_y);

   assign bm5 = b5_ff[63] ? 63'(-b5_ff) : b5_ff[62:0];
   assign am5 = a5_ff[63] ? 63'(-a5_ff) : a5_ff[62:0];
   assign tm5 = tb5_ff[31] ? 32'(-tb5_ff) : 32'(tb5_ff);

   always_comb begin
      l_val = lneg7_ff ? -signed'(LW'(lm7_ff)) : signed'(LW'(lm7_ff));
      r_val = LW'(a7_ff) <<< FRAC_BITS;
      job_in.bound = tb7_ff;
      job_in.b_mag = bm7_ff;
      job_in.dv2   = dv27_ff;
      job_in.disc  = a7_ff[63] ? (p7_ff - q7_ff) : (p7_ff + q7_ff);
      if (bpos7_ff) begin
         job_in.outcome = OUT_APART;
      end else if (l_val > r_val) begin
         job_in.outcome = OUT_REJECT;
      end else if (a7_ff[63] && (q7_ff > p7_ff)) begin
         job_in.outcome = OUT_NO_ROOT;
      end else if (dv27_ff == '0) begin
         job_in.outcome = OUT_LATE;
      end else begin
         job_in.outcome = OUT_HIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         shx_ff   <= mul_x >>> FRAC_BITS;
         shy_ff   <= mul_y >>> FRAC_BITS;
         dax_ff   <= 33'(a_pos_x) - 33'(b_pos_x);
         day_ff   <= 33'(a_pos_y) - 33'(b_pos_y);
         dvx1_ff  <= sat31(66'(a_vel_x) - 66'(b_vel_x));
         dvy1_ff  <= sat31(66'(a_vel_y) - 66'(b_vel_y));
         cd1_ff   <= contact_distance;
         edge1_ff <= near_edge;
         tb1_ff   <= bound_in;

         dx2_ff   <= 66'(dax_ff) - 66'(shx_ff);
         dy2_ff   <= 66'(day_ff) - 66'(shy_ff);
         dvx2_ff  <= dvx1_ff;
         dvy2_ff  <= dvy1_ff;
         cd2_ff   <= cd1_ff;
         edge2_ff <= edge1_ff;
         tb2_ff   <= tb1_ff;

         dx3_ff  <= sat31(edge2_ff ? fold(dx2_ff, box_width) : dx2_ff);
         dy3_ff  <= sat31(edge2_ff ? fold(dy2_ff, box_height) : dy2_ff);
         dvx3_ff <= dvx2_ff;
         dvy3_ff <= dvy2_ff;
         cd3_ff  <= cd2_ff;
         tb3_ff  <= tb2_ff;

         bx4_ff <= 64'(dx3_ff) * 64'(dvx3_ff);
         by4_ff <= 64'(dy3_ff) * 64'(dvy3_ff);
         xx4_ff <= 62'(64'(dx3_ff) * 64'(dx3_ff));
         yy4_ff <= 62'(64'(dy3_ff) * 64'(dy3_ff));
         vx4_ff <= 62'(64'(dvx3_ff) * 64'(dvx3_ff));
         vy4_ff <= 62'(64'(dvy3_ff) * 64'(dvy3_ff));
         cc4_ff <= 62'(64'(cd3_ff) * 64'(cd3_ff));
         tb4_ff <= tb3_ff;

         b5_ff   <= bx4_ff + by4_ff;
         a5_ff   <= 64'(66'(cc4_ff) - (66'(xx4_ff) + 66'(yy4_ff)));
         dv25_ff <= 63'(vx4_ff) + 63'(vy4_ff);
         tb5_ff  <= tb4_ff;

         lp0_ff   <= 64'(bm5[31:0]) * 64'(tm5);
         lp1_ff   <= 64'(bm5[62:32]) * 64'(tm5);
         pp0_ff   <= 64'(bm5[31:0]) * 64'(bm5[31:0]);
         pp1_ff   <= 64'(bm5[31:0]) * 64'(bm5[62:32]);
         pp2_ff   <= 64'(bm5[62:32]) * 64'(bm5[62:32]);
         qp0_ff   <= 64'(dv25_ff[31:0]) * 64'(am5[31:0]);
         qp1_ff   <= 64'(dv25_ff[31:0]) * 64'(am5[62:32]);
         qp2_ff   <= 64'(dv25_ff[62:32]) * 64'(am5[31:0]);
         qp3_ff   <= 64'(dv25_ff[62:32]) * 64'(am5[62:32]);
         bpos6_ff <= (b5_ff > 64'sd0);
         lneg6_ff <= b5_ff[63] ^ tb5_ff[31];
         a6_ff    <= a5_ff;
         dv26_ff  <= dv25_ff;
         bm6_ff   <= bm5;
         tb6_ff   <= tb5_ff;

         lm7_ff   <= (96'(lp0_ff) + (96'(lp1_ff) << 32)) << 1;
         p7_ff    <= 128'(pp0_ff) + (128'(pp1_ff) << 33) + (128'(pp2_ff) << 64);
         q7_ff    <= 128'(qp0_ff) + ((128'(qp1_ff) + 128'(qp2_ff)) << 32)
                     + (128'(qp3_ff) << 64);
         bpos7_ff <= bpos6_ff;
         lneg7_ff <= lneg6_ff;
         a7_ff    <= a6_ff;
         dv27_ff  <= dv26_ff;
         bm7_ff   <= bm6_ff;
         tb7_ff   <= tb6_ff;

         job_ff <= job_in;
      end
   end

   assign job_valid = vld_ff[7];
   assign job       = job_ff;

endmodule

// ----- design/hdct_queue.sv -----
// Short word queue between the front classifier and the back solver.
module hdct_queue
   import hdct_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  hdct_job_type push_data,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output hdct_job_type head
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   hdct_job_type  mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count above depth");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_ff) + CW'($past(do_push)) - CW'($past(do_pop)))
      else $error("queue count does not follow push and pop");
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");
`endif

endmodule

// ----- design/hdct_back.sv -----
// Back pipeline: square root and division stages, then the final bound test.
module hdct_back
   import hdct_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  hdct_job_type       job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_bound_out,
   output logic [2:0]         rsp_outcome
);

   localparam int QW = 64 + FRAC_BITS;
   localparam int NS = SQRT_STEPS + QW + 3;

   typedef struct packed {
      hdct_outcome_type   outcome;
      logic signed [31:0] bound;
      logic               neg;
      logic [62:0]        dv2;
      logic [QW-1:0]      num;
      logic [62:0]        rem;
      logic [QW-1:0]      quo;
   } hdct_div_type;

   function automatic hdct_sqrt_type sqrt_step(input hdct_sqrt_type s);
      hdct_sqrt_type r;
      logic [66:0]   trial_rem;
      logic [66:0]   trial;
      r = s;
      trial_rem = {s.rem, s.rad[127:126]};
      trial = {1'b0, s.root, 2'b01};
      r.rad = {s.rad[125:0], 2'b00};
      if (trial_rem >= trial) begin
         r.rem  = 65'(trial_rem - trial);
         r.root = {s.root[62:0], 1'b1};
      end else begin
         r.rem  = trial_rem[64:0];
         r.root = {s.root[62:0], 1'b0};
      end
      return r;
   endfunction

   function automatic hdct_div_type div_step(input hdct_div_type s);
      hdct_div_type r;
      logic [63:0]  trial;
      r = s;
      trial = {s.rem, s.num[QW-1]};
      r.num = {s.num[QW-2:0], 1'b0};
      if (trial >= {1'b0, s.dv2}) begin
         r.rem = 63'(trial - {1'b0, s.dv2});
         r.quo = {s.quo[QW-2:0], 1'b1};
      end else begin
         r.rem = trial[62:0];
         r.quo = {s.quo[QW-2:0], 1'b0};
      end
      return r;
   endfunction

   logic [NS-1:0] vld_ff, vld_in;
   logic          adv;

   hdct_sqrt_type sq_ff [SQRT_STEPS + 1];
   hdct_sqrt_type sq_in [SQRT_STEPS + 1];
   hdct_div_type  dv_ff [QW + 1];
   hdct_div_type  dv_in [QW + 1];

   logic [63:0]          nb;
   logic [QW:0]          qm;
   logic signed [QW+1:0] t_val, tb_ext, t_min;
   logic                 is_hit;

   logic               out_hit_ff, out_hit_in;
   logic signed [31:0] out_bound_ff, out_bound_in;
   hdct_outcome_type   out_outcome_ff, out_outcome_in;

   assign adv    = !(vld_ff[NS-1] && rsp_stall);
   assign pop    = adv;
   assign vld_in = {vld_ff[NS-2:0], job_valid};

   always_comb begin
      sq_in[0].outcome = job.outcome;
      sq_in[0].bound   = job.bound;
      sq_in[0].b_mag   = job.b_mag;
      sq_in[0].dv2     = job.dv2;
      sq_in[0].rad     = job.disc;
      sq_in[0].rem     = '0;
      sq_in[0].root    = '0;
   end

   for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
      assign sq_in[k] = sqrt_step(sq_ff[k-1]);
   end

   always_comb begin
      nb = {1'b0, sq_ff[SQRT_STEPS].b_mag};
      dv_in[0].outcome = sq_ff[SQRT_STEPS].outcome;
      dv_in[0].bound   = sq_ff[SQRT_STEPS].bound;
      dv_in[0].dv2     = sq_ff[SQRT_STEPS].dv2;
      dv_in[0].rem     = '0;
      dv_in[0].quo     = '0;
      if (sq_ff[SQRT_STEPS].root <= nb) begin
         dv_in[0].neg = 1'b0;
         dv_in[0].num = {nb - sq_ff[SQRT_STEPS].root, {FRAC_BITS{1'b0}}};
      end else begin
         dv_in[0].neg = 1'b1;
         dv_in[0].num = {sq_ff[SQRT_STEPS].root - nb, {FRAC_BITS{1'b0}}};
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_div
      assign dv_in[k] = div_step(dv_ff[k-1]);
   end

   always_comb begin
      qm     = (QW + 1)'(dv_ff[QW].quo) + (QW + 1)'(dv_ff[QW].neg && (dv_ff[QW].rem != '0));
      t_val  = dv_ff[QW].neg ? -signed'({1'b0, qm}) : signed'({1'b0, qm});
      tb_ext = (QW + 2)'(dv_ff[QW].bound);
      t_min  = (QW + 2)'(signed'(32'h8000_0000));
      is_hit = (dv_ff[QW].outcome == OUT_HIT) && (tb_ext > t_val);
      out_hit_in     = is_hit;
      out_bound_in   = dv_ff[QW].bound;
      out_outcome_in = dv_ff[QW].outcome;
      if (is_hit) begin
         out_bound_in = (t_val < t_min) ? 32'sh8000_0000 : t_val[31:0];
      end else if (dv_ff[QW].outcome == OUT_HIT) begin
         out_outcome_in = OUT_LATE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   for (genvar k = 0; k <= SQRT_STEPS; k++) begin : g_sqrt_reg
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[k] <= sq_in[k];
         end
      end
   end

   for (genvar k = 0; k <= QW; k++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_hit_ff     <= out_hit_in;
         out_bound_ff   <= out_bound_in;
         out_outcome_ff <= out_outcome_in;
      end
   end

   assign rsp_valid     = vld_ff[NS-1];
   assign rsp_hit       = out_hit_ff;
   assign rsp_bound_out = out_bound_ff;
   assign rsp_outcome   = out_outcome_ff;

`ifndef ASSERT_OFF
   a_hit_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit == (out_outcome_ff == OUT_HIT)))
      else $error("hit flag and outcome disagree");
   a_frozen: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("back pipeline moved while held");
`endif

endmodule

// ----- tb/hdct_checker.sv -----
// Checker that predicts each contact-time result and compares it with the block's output.
`timescale 1ns / 100ps
module hdct_checker
   import hdct_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_a_pos_x,
   input  logic signed [31:0] req_a_pos_y,
   input  logic signed [31:0] req_a_vel_x,
   input  logic signed [31:0] req_a_vel_y,
   input  logic signed [31:0] req_b_pos_x,
   input  logic signed [31:0] req_b_pos_y,
   input  logic signed [31:0] req_b_vel_x,
   input  logic signed [31:0] req_b_vel_y,
   input  logic [30:0]        req_b_age,
   input  logic [30:0]        req_contact_distance,
   input  logic               req_near_edge,
   input  logic signed [31:0] req_bound_in,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_hit,
   input  logic signed [31:0] rsp_bound_out,
   input  logic [2:0]         rsp_outcome,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output int                 fail_count,
   output int                 pending_count
);

   typedef struct {
      logic               hit;
      logic signed [31:0] bound;
      hdct_outcome_type   outcome;
   } contact_type;

   contact_type contact_queue[$];
   logic [30:0] width_reg;
   logic [30:0] height_reg;

   assign pending_count = contact_queue.size();

   function automatic logic signed [63:0] shift_floor(logic signed [63:0] p);
      return p >>> FRAC_BITS;
   endfunction

   function automatic logic signed [63:0] wrap_axis(logic signed [63:0] d,
                                                    logic signed [63:0] s);
      if (2 * d > s) begin
         return d - s;
      end else if (2 * d < -s) begin
         return d + s;
      end
      return d;
   endfunction

   function automatic logic signed [63:0] clamp31(logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483647) begin
         return -64'sd2147483647;
      end
      return v;
   endfunction

   function automatic logic [63:0] root_floor(logic [127:0] x);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         c = r | (64'd1 << i);
         if (128'(c) * 128'(c) <= x) begin
            r = c;
         end
      end
      return r;
   endfunction

   function automatic contact_type predict_contact(
      logic signed [31:0] ax, logic signed [31:0] ay,
      logic signed [31:0] avx, logic signed [31:0] avy,
      logic signed [31:0] bx, logic signed [31:0] by,
      logic signed [31:0] bvx, logic signed [31:0] bvy,
      logic [30:0] age, logic [30:0] cd, logic edge_flag,
      logic signed [31:0] tb);
      contact_type r;
      logic signed [63:0] dx, dy, dvx, dvy, dv2;
      logic signed [63:0] age_s, cd_s;
      logic signed [159:0] bb, aa, lhs, rhs, disc, num, t, s, dvw;
      age_s = 64'(age);
      cd_s = 64'(cd);
      r.hit = 1'b0;
      r.bound = tb;
      dx = 64'(ax) - 64'(bx) - shift_floor(age_s * 64'(bvx));
      dy = 64'(ay) - 64'(by) - shift_floor(age_s * 64'(bvy));
      if (edge_flag) begin
         dx = wrap_axis(dx, 64'(width_reg));
         dy = wrap_axis(dy, 64'(height_reg));
      end
      dx = clamp31(dx);
      dy = clamp31(dy);
      dvx = clamp31(64'(avx) - 64'(bvx));
      dvy = clamp31(64'(avy) - 64'(bvy));
      bb = 160'(dx) * 160'(dvx) + 160'(dy) * 160'(dvy);
      if (bb > 0) begin
         r.outcome = OUT_APART;
         return r;
      end
      aa = 160'(cd_s) * 160'(cd_s) - (160'(dx) * 160'(dx) + 160'(dy) * 160'(dy));
      lhs = 2 * bb * 160'(tb);
      rhs = aa <<< FRAC_BITS;
      if (lhs > rhs) begin
         r.outcome = OUT_REJECT;
         return r;
      end
      dv2 = dvx * dvx + dvy * dvy;
      dvw = 160'(dv2);
      disc = bb * bb + dvw * aa;
      if (disc < 0) begin
         r.outcome = OUT_NO_ROOT;
         return r;
      end
      if (dv2 == 0) begin
         r.outcome = OUT_LATE;
         return r;
      end
      s = 160'(root_floor(disc[127:0]));
      num = (-bb - s) <<< FRAC_BITS;
      if (num >= 0) begin
         t = num / dvw;
      end else begin
         t = -((-num + dvw - 1) / dvw);
      end
      if (!(160'(tb) > t)) begin
         r.outcome = OUT_LATE;
         return r;
      end
      r.hit = 1'b1;
      r.outcome = OUT_HIT;
      r.bound = (t < -160'sd2147483648) ? 32'sh80000000 : t[31:0];
      return r;
   endfunction

   always @(posedge clock) begin
      contact_type e;
      if (reset) begin
         width_reg <= 31'd4194304;
         height_reg <= 31'd4194304;
         fail_count <= 0;
         contact_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[2] == 1'(REG_BOX_HEIGHT)) begin
               height_reg <= csr_pwdata[30:0];
            end else begin
               width_reg <= csr_pwdata[30:0];
            end
         end
         if (req_valid && !req_stall) begin
            contact_queue.push_back(predict_contact(req_a_pos_x, req_a_pos_y, req_a_vel_x,
               req_a_vel_y, req_b_pos_x, req_b_pos_y, req_b_vel_x, req_b_vel_y, req_b_age,
               req_contact_distance, req_near_edge, req_bound_in));
         end
         if (rsp_valid && !rsp_stall) begin
            if (contact_queue.size() == 0) begin
               $error("result word with no expectation waiting");
               fail_count <= fail_count + 1;
            end else begin
               e = contact_queue.pop_front();
               if (rsp_hit !== e.hit || rsp_bound_out !== e.bound
                   || rsp_outcome !== 3'(e.outcome)) begin
                  fail_count <= fail_count + 1;
                  if (rsp_hit !== e.hit) begin
                     $error("hit: expected %0d, actual %0d", e.hit, rsp_hit);
                  end
                  if (rsp_bound_out !== e.bound) begin
                     $error("bound_out: expected %0d, actual %0d", e.bound, rsp_bound_out);
                  end
                  if (rsp_outcome !== 3'(e.outcome)) begin
                     $error("outcome: expected %0d, actual %0d", e.outcome, rsp_outcome);
                  end
               end
            end
         end
      end
   end

endmodule

// ----- tb/tb_top.sv -----
// Stimulus, configuration and verdict for the hard-disk contact time engine.
`timescale 1ns / 100ps
module tb_top
   import hdct_pkg::*;
();

   localparam int LATENCY = 156;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_a_pos_x = '0, req_a_pos_y = '0, req_a_vel_x = '0, req_a_vel_y = '0;
   logic signed [31:0] req_b_pos_x = '0, req_b_pos_y = '0, req_b_vel_x = '0, req_b_vel_y = '0;
   logic [30:0] req_b_age = '0, req_contact_distance = '0;
   logic req_near_edge = 1'b0;
   logic signed [31:0] req_bound_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic signed [31:0] rsp_bound_out;
   logic [2:0] rsp_outcome;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   int fail_count;
   int pending_count;
   int idle_cycles = 0;
   int hold_cycles = 0;
   int pause_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   hard_disk_collision_time_top dut (.*);

   hdct_checker checker_inst (.*);

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver stalls: short random gaps, occasional long ones, one long hold.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (pause_cycles > 0) begin
         pause_cycles <= pause_cycles - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
         pause_cycles <= $urandom_range(20, 60);
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic signed [31:0] pick_value(int mode);
      case ($urandom_range(0, mode))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'(signed'($urandom_range(0, 2 ** 22)) - 2 ** 21);
         3: return 32'($urandom_range(0, 255)) - 128;
         default: return $urandom;
      endcase
   endfunction

   task automatic csr_write(int index, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * index);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_pair(logic signed [31:0] ax, logic signed [31:0] ay,
                            logic signed [31:0] avx, logic signed [31:0] avy,
                            logic signed [31:0] bx, logic signed [31:0] by,
                            logic signed [31:0] bvx, logic signed [31:0] bvy,
                            logic [30:0] age, logic [30:0] cd, logic edge_flag,
                            logic signed [31:0] tb, bit allow_gap);
      int gap;
      if (allow_gap && $urandom_range(0, 2) == 0) begin
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_a_pos_x <= ax;
      req_a_pos_y <= ay;
      req_a_vel_x <= avx;
      req_a_vel_y <= avy;
      req_b_pos_x <= bx;
      req_b_pos_y <= by;
      req_b_vel_x <= bvx;
      req_b_vel_y <= bvy;
      req_b_age <= age;
      req_contact_distance <= cd;
      req_near_edge <= edge_flag;
      req_bound_in <= tb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random(int count, bit allow_gap);
      logic signed [31:0] ax, ay, vx, vy;
      logic [30:0] cd;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 7) begin
            // Plausible pairs, B roughly mirroring A, with random detail.
            ax = 32'($urandom_range(0, 2 ** 22)) - 2 ** 21;
            ay = 32'($urandom_range(0, 2 ** 22)) - 2 ** 21;
            vx = 32'($urandom_range(0, 2 ** 18)) - 2 ** 17;
            vy = 32'($urandom_range(0, 2 ** 18)) - 2 ** 17;
            cd = 31'($urandom_range(0, 2 ** 20));
            send_pair(ax, ay, vx, vy, -ax + 32'($urandom_range(0, 65535)), -ay,
                      -vx + 32'($urandom_range(0, 2 ** 16)), -vy, 31'($urandom_range(0, 2 ** 17)),
                      cd, 1'($urandom), 32'($urandom_range(0, 2 ** 24)), allow_gap);
         end else begin
            send_pair(pick_value(5), pick_value(5), pick_value(5), pick_value(5),
                      pick_value(5), pick_value(5), pick_value(5), pick_value(5),
                      31'($urandom), 31'($urandom), 1'($urandom), pick_value(5), allow_gap);
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic drain;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, each outcome, fold, saturation.
      send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
      send_pair(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                31'h7fffffff, 31'h7fffffff, 1'b1, 32'sh7fffffff, 1'b0);
      send_pair(32'sh00100000, 0, 32'shfff00000, 0, 0, 0, 0, 0, 0,
                31'h10000, 1'b0, 32'sh7fffffff, 1'b0);
      send_pair(32'sh00100000, 0, 32'sh00010000, 0, 0, 0, 0, 0, 0,
                31'h10000, 1'b0, 32'sh7fffffff, 1'b0);
      send_pair(32'sh00100000, 0, 32'shffff0000, 0, 0, 0, 0, 0, 0,
                31'h10000, 1'b0, 32'sh00010000, 1'b0);
      send_pair(32'sh00100000, 32'sh00100000, 32'shffff0000, 0, 0, 0, 0, 0, 0,
                31'h10000, 1'b0, 32'sh7fffffff, 1'b0);
      send_pair(0, 0, 0, 0, 32'sh00008000, 0, 0, 0, 0,
                31'h10000, 1'b0, 32'sh00010000, 1'b0);
      send_pair(32'sh003e0000, 0, 32'sh00010000, 0, 0, 0, 0, 0, 31'h00010000,
                31'h10000, 1'b1, 32'sh7fffffff, 1'b0);
      send_pair(0, 0, 0, 0, 0, 32'sh003f0000, 0, 32'sh00010000, 31'h00020000,
                31'h10000, 1'b1, 32'sh7fffffff, 1'b0);
      send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 31'h10000, 1'b0, 32'sh80000000, 1'b0);
      send_pair(0, 0, 32'sh00000001, 0, 32'sh00000010, 0, 0, 0, 0,
                31'h7fffffff, 1'b0, 32'sh7fffffff, 1'b0);
      send_pair(32'sh00200000, 0, 32'shfff00000, 0, 0, 0, 0, 0, 0,
                31'h10000, 1'b0, 32'sh80000000, 1'b0);
      req_valid <= 1'b0;
      drain();

      send_random(300, 1'b1);
      drain();
      csr_write(REG_BOX_WIDTH, 32'd1);
      csr_write(REG_BOX_HEIGHT, 32'h7fffffff);
      send_random(300, 1'b1);

      // Long receiver hold while the sender keeps offering words.
      hold_cycles <= 300;
      send_random(250, 1'b0);
      drain();
      csr_write(REG_BOX_WIDTH, 32'h7fffffff);
      csr_write(REG_BOX_HEIGHT, 32'd1);
      send_random(300, 1'b1);
      drain();
      csr_write(REG_BOX_WIDTH, 32'h00100000);
      csr_write(REG_BOX_HEIGHT, 32'h00280000);
      send_random(190, 1'b1);
      drain();

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/hdct_pkg.sv
design/hdct_front.sv
design/hdct_queue.sv
design/hdct_back.sv
design/hard_disk_collision_time_top.sv
tb/hdct_checker.sv
tb/tb_top.sv
